>>> design/cst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, character constants and parse-step functions of the CSV tokenizer.
// No dependencies; imported by every module of the block.
package cst_pkg;

  localparam int FIELD_W = 8;
  localparam int LINE_W = 16;
  localparam int MAX_FIELDS = 255;
  localparam int CST_QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_COUNT_ERR = 2'd1;
  localparam logic [1:0] ST_EOI       = 2'd2;

  typedef enum logic [2:0] {
    MODE_LINE, MODE_FSTART, MODE_PLAIN, MODE_QUOTED, MODE_QSEEN, MODE_COMMENT
  } mode_t;

  typedef struct packed {
    mode_t               mode;
    logic [FIELD_W-1:0]  learned;
    logic [FIELD_W-1:0]  fcount;
    logic [LINE_W-1:0]   lines;
    logic                err;
  } pst_t;

  typedef struct packed {
    logic [7:0]        data;
    logic              has;
    logic              fe;
    logic              re;
    logic [1:0]        status;
    logic [LINE_W-1:0] recnum;
  } res_t;

  // One queue entry: all results caused by one input item.
  typedef struct packed {
    logic [1:0]      cnt;
    res_t [2:0]      slot;
  } bundle_t;

  typedef struct packed {
    pst_t       s;
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } feed_t;

  typedef struct packed {
    pst_t s;
    res_t r;
  } close_t;

  function automatic res_t cst_mk_res(logic [7:0] b, logic has, logic fe, logic re,
                                      logic [1:0] st, logic [LINE_W-1:0] ln);
    res_t r;
    r.data   = b;
    r.has    = has;
    r.fe     = fe;
    r.re     = re;
    r.status = st;
    r.recnum = ln;
    return r;
  endfunction

  function automatic logic [LINE_W-1:0] cst_bump(logic [LINE_W-1:0] ln);
    return (ln == '1) ? ln : LINE_W'(ln + 1'b1);
  endfunction

  function automatic logic cst_blank(logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic [1:0] cst_err_status(logic err);
    return err ? ST_COUNT_ERR : ST_OK;
  endfunction

  // Close the current field; on a record end also check or learn the count.
  function automatic close_t cst_close(pst_t s, logic [FIELD_W-1:0] expf, logic rec);
    close_t             c;
    logic [FIELD_W-1:0] target;
    c.s = s;
    if (s.fcount < FIELD_W'(MAX_FIELDS)) begin
      c.s.fcount = FIELD_W'(s.fcount + 1'b1);
    end
    target = (expf != '0) ? expf : s.learned;
    if (rec) begin
      if (target == '0) begin
        c.s.learned = c.s.fcount;
      end else if (target != c.s.fcount) begin
        c.s.err = 1'b1;
      end
      c.s.fcount = '0;
    end
    c.r = cst_mk_res(8'h00, 1'b0, 1'b1, rec, cst_err_status(c.s.err), c.s.lines);
    return c;
  endfunction

  function automatic feed_t cst_push(feed_t f, res_t r);
    feed_t g;
    g = f;
    if (f.n == 2'd0) begin
      g.r0 = r;
    end else begin
      g.r1 = r;
    end
    g.n = 2'(f.n + 2'd1);
    return g;
  endfunction

  // Parse one character (CR folding already done by the caller).
  function automatic feed_t cst_feed(pst_t s, logic [FIELD_W-1:0] expf, logic [7:0] c);
    feed_t  f;
    close_t cl;
    mode_t  m;
    logic   done;
    f.s  = s;
    f.n  = 2'd0;
    f.r0 = '0;
    f.r1 = '0;
    cl   = '0;
    m    = s.mode;
    done = 1'b0;
    if (m == MODE_LINE) begin
      f.s.lines = cst_bump(s.lines);
      if (c == CH_HASH) begin
        f.s.mode = MODE_COMMENT;
        done = 1'b1;
      end else if (c == CH_LF) begin
        done = 1'b1;
      end else begin
        m = MODE_FSTART;
        f.s.mode = MODE_FSTART;
      end
    end
    if (!done) begin
      unique case (m)
        MODE_LINE: begin
        end
        MODE_FSTART: begin
          if (cst_blank(c)) begin
          end else if (c == CH_COMMA) begin
            cl = cst_close(f.s, expf, 1'b0);
            f.s = cl.s;
            f = cst_push(f, cl.r);
          end else if (c == CH_LF) begin
            cl = cst_close(f.s, expf, 1'b1);
            f.s = cl.s;
            f = cst_push(f, cl.r);
            f.s.mode = MODE_LINE;
          end else if (c == CH_QUOTE) begin
            f.s.mode = MODE_QUOTED;
          end else begin
            f = cst_push(f, cst_mk_res(c, 1'b1, 1'b0, 1'b0, cst_err_status(f.s.err),
                                       f.s.lines));
            f.s.mode = MODE_PLAIN;
          end
        end
        MODE_PLAIN: begin
          if (c == CH_COMMA || c == CH_LF) begin
            cl = cst_close(f.s, expf, c == CH_LF);
            f.s = cl.s;
            f = cst_push(f, cl.r);
            f.s.mode = (c == CH_LF) ? MODE_LINE : MODE_FSTART;
          end else begin
            f = cst_push(f, cst_mk_res(c, 1'b1, 1'b0, 1'b0, cst_err_status(f.s.err),
                                       f.s.lines));
          end
        end
        MODE_QUOTED: begin
          if (c == CH_QUOTE) begin
            f.s.mode = MODE_QSEEN;
          end else begin
            if (c == CH_LF) begin
              f.s.lines = cst_bump(f.s.lines);
            end
            f = cst_push(f, cst_mk_res(c, 1'b1, 1'b0, 1'b0, cst_err_status(f.s.err),
                                       f.s.lines));
          end
        end
        MODE_QSEEN: begin
          if (c == CH_QUOTE) begin
            f = cst_push(f, cst_mk_res(c, 1'b1, 1'b0, 1'b0, cst_err_status(f.s.err),
                                       f.s.lines));
            f.s.mode = MODE_QUOTED;
          end else if (c == CH_COMMA || c == CH_LF) begin
            cl = cst_close(f.s, expf, c == CH_LF);
            f.s = cl.s;
            f = cst_push(f, cl.r);
            f.s.mode = (c == CH_LF) ? MODE_LINE : MODE_FSTART;
          end else begin
            // Lazy quote: keep the bare quote and the byte as data.
            f = cst_push(f, cst_mk_res(CH_QUOTE, 1'b1, 1'b0, 1'b0,
                                       cst_err_status(f.s.err), f.s.lines));
            f = cst_push(f, cst_mk_res(c, 1'b1, 1'b0, 1'b0, cst_err_status(f.s.err),
                                       f.s.lines));
            f.s.mode = MODE_QUOTED;
          end
        end
        MODE_COMMENT: begin
          if (c == CH_LF) begin
            f.s.mode = MODE_LINE;
          end
        end
        default: begin
          f.s.mode = MODE_LINE;
        end
      endcase
    end
    return f;
  endfunction

endpackage
`default_nettype wire

>>> design/cst_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front end: accepts input items, folds CR LF, runs the parse step and
// pushes one bundle of results per item that yields any into the queue. Uses cst_pkg.
module cst_front import cst_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_kind,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [FIELD_W-1:0] cfg_expected_fields,
  output logic                    q_push,
  output bundle_t                 q_data,
  input  wire logic               q_full
);

  pst_t               state_r, state_nxt;
  logic               pend_r, pend_nxt;
  logic [FIELD_W-1:0] expf_r, expf_nxt;

  logic       accept;
  logic       is_data, use1, use2, skip, open_field;
  logic [7:0] c1;
  feed_t      fa, fb;
  pst_t       sa;
  close_t     ce;
  logic [1:0] na, nb;
  res_t       eoi_res;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  // Parse step: a held CR is fed first, then the new byte.
  always_comb begin
    is_data    = (in_kind == KIND_DATA);
    skip       = pend_r && (in_data_byte == CH_LF);
    use1       = is_data && pend_r;
    use2       = is_data && !skip && (in_data_byte != CH_CR);
    c1         = skip ? CH_LF : CH_CR;
    fa         = cst_feed(state_r, expf_r, c1);
    sa         = use1 ? fa.s : state_r;
    fb         = cst_feed(sa, expf_r, in_data_byte);
    open_field = (state_r.mode == MODE_FSTART) || (state_r.mode == MODE_PLAIN) ||
                 (state_r.mode == MODE_QUOTED) || (state_r.mode == MODE_QSEEN);
    ce         = cst_close(state_r, expf_r, 1'b1);
    na         = use1 ? fa.n : 2'd0;
    nb         = use2 ? fb.n : 2'd0;
    eoi_res    = cst_mk_res(8'h00, 1'b0, 1'b0, 1'b0, ST_EOI, state_r.lines);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    expf_nxt  = cfg_valid ? cfg_expected_fields : expf_r;
    if (accept) begin
      if (is_data) begin
        state_nxt = use2 ? fb.s : sa;
        pend_nxt  = (in_data_byte == CH_CR);
      end else begin
        state_nxt        = open_field ? ce.s : state_r;
        state_nxt.mode   = MODE_LINE;
        state_nxt.fcount = '0;
        pend_nxt         = 1'b0;
      end
    end
  end

  // Result bundle toward the queue.
  always_comb begin
    q_data = '0;
    if (is_data) begin
      q_data.cnt     = 2'(na + nb);
      q_data.slot[0] = (na != 2'd0) ? fa.r0 : fb.r0;
      q_data.slot[1] = (na == 2'd2) ? fa.r1 : ((na == 2'd1) ? fb.r0 : fb.r1);
      q_data.slot[2] = (na == 2'd2) ? fb.r0 : fb.r1;
    end else if (open_field) begin
      q_data.cnt     = 2'd2;
      q_data.slot[0] = ce.r;
      q_data.slot[1] = eoi_res;
    end else begin
      q_data.cnt     = 2'd1;
      q_data.slot[0] = eoi_res;
    end
    q_push = accept && (q_data.cnt != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode    <= MODE_LINE;
      state_r.learned <= '0;
      state_r.fcount  <= '0;
      state_r.lines   <= '0;
      state_r.err     <= 1'b0;
      pend_r          <= 1'b0;
      expf_r          <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      expf_r  <= expf_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/cst_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Short register queue of result bundles between front and back end.
// Uses cst_pkg for the bundle type.
module cst_queue import cst_pkg::*; #(
  parameter int DEPTH = CST_QUEUE_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire bundle_t push_data,
  output logic         full,
  input  wire logic    pop,
  output bundle_t      pop_data,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wptr_r + 1'b1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rptr_r + 1'b1);
    end
    if (push && !pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/cst_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Back end: takes one bundle at a time from the queue and hands its results
// out one per cycle while out_stall is low, from a register. Uses cst_pkg.
module cst_back import cst_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire bundle_t     q_data,
  input  wire logic        q_empty,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_has_byte,
  output logic             out_field_end,
  output logic             out_record_end,
  output logic [1:0]       out_status,
  output logic [LINE_W-1:0] out_record_number,
  output logic             out_last
);

  bundle_t    cur_r, cur_nxt;
  logic       cur_valid_r, cur_valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       fire, last_slot, done, load;
  res_t       sel;

  assign out_valid = cur_valid_r;
  assign fire      = cur_valid_r && !out_stall;
  assign last_slot = (idx_r == 2'(cur_r.cnt - 2'd1));
  assign done      = fire && last_slot;
  assign load      = !q_empty && (!cur_valid_r || done);
  assign q_pop     = load;

  always_comb begin
    case (idx_r)
      2'd0:    sel = cur_r.slot[0];
      2'd1:    sel = cur_r.slot[1];
      default: sel = cur_r.slot[2];
    endcase
    out_byte          = sel.data;
    out_has_byte      = sel.has;
    out_field_end     = sel.fe;
    out_record_end    = sel.re;
    out_status        = sel.status;
    out_record_number = sel.recnum;
    out_last          = last_slot;
  end

  always_comb begin
    cur_nxt       = load ? q_data : cur_r;
    cur_valid_nxt = load ? 1'b1 : (done ? 1'b0 : cur_valid_r);
    idx_nxt       = load ? 2'd0 : (fire ? 2'(idx_r + 2'd1) : idx_r);
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/csv_stream_tokenizer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// CSV stream tokenizer, top level. Uses cst_pkg, cst_front, cst_queue, cst_back.
//
// Input channel (in_valid / in_stall): one item per accepted edge, either a raw
// byte (in_kind = 0) or an end-of-input mark (in_kind = 1). Result channel
// (out_valid / out_stall): field bytes, field-end and record-end marks, status
// and record number, with out_last on the final result of each input item.
// Config channel (cfg_valid / cfg_ready, always ready): expected field count,
// 0 to learn it from the first record; write it only while the block is idle.
// Throughput: one input item per cycle while in_stall is low. Each item yields zero to
// three results, and the back end delivers one result per cycle while out_stall is low,
// so sustained input throughput is bounded by the result count. An item's results pass
// through the queue write and then the output register before they can be taken.
// A stalled receiver holds the current result; the front end keeps accepting
// until the bundle queue (QUEUE_DEPTH entries) is full, then raises in_stall.
// Reset returns the parser to line start, clears counters, learned count,
// error flag and the expected-field register, and empties the queue.
module csv_stream_tokenizer_top import cst_pkg::*; #(
  parameter int QUEUE_DEPTH = CST_QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_kind,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [FIELD_W-1:0] cfg_expected_fields,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_byte,
  output logic                    out_has_byte,
  output logic                    out_field_end,
  output logic                    out_record_end,
  output logic [1:0]              out_status,
  output logic [LINE_W-1:0]       out_record_number,
  output logic                    out_last
);

  // Bundle queue handshake between front and back end.
  logic    q_push, q_full, q_pop, q_empty;
  bundle_t q_wdata, q_rdata;

  // Front: classify each item and build its result bundle.
  cst_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_data_byte        (in_data_byte),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_expected_fields (cfg_expected_fields),
    .q_push              (q_push),
    .q_data              (q_wdata),
    .q_full              (q_full)
  );

  // Queue: decouple input acceptance from result delivery.
  cst_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // Back: serialize each bundle, one result per cycle while out_stall is low.
  cst_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_data            (q_rdata),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_has_byte      (out_has_byte),
    .out_field_end     (out_field_end),
    .out_record_end    (out_record_end),
    .out_status        (out_status),
    .out_record_number (out_record_number),
    .out_last          (out_last)
  );

endmodule
`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for csv_stream_tokenizer_top: drives byte and end-of-input items,
// predicts every token result and checks it field by field. Depends on cst_pkg and the RTL.
module tb_top;
  import cst_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 40;

  // One predicted result of the tokenizer.
  typedef struct {
    logic [7:0]        tok_byte;
    logic              has;
    logic              fe;
    logic              re;
    logic [1:0]        status;
    logic [LINE_W-1:0] recno;
    logic              last;
  } token_t;

  logic                clk                 = 1'b0;
  logic                rst_n               = 1'b0;
  logic                in_valid            = 1'b0;
  logic                in_kind             = KIND_DATA;
  logic [7:0]          in_data_byte        = 8'h00;
  logic                cfg_valid           = 1'b0;
  logic [FIELD_W-1:0]  cfg_expected_fields = '0;
  logic                out_stall           = 1'b0;
  logic                in_stall;
  logic                cfg_ready;
  logic                out_valid;
  logic [7:0]          out_byte;
  logic                out_has_byte;
  logic                out_field_end;
  logic                out_record_end;
  logic [1:0]          out_status;
  logic [LINE_W-1:0]   out_record_number;
  logic                out_last;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int          cycles    = 0;
  int          err_count = 0;
  int          sent_items = 0;

  // Tokens still owed by the block, oldest first.
  token_t      owed_tokens[$];
  token_t      step_tokens[$];

  // Tokenizer state as the bench tracks it.
  mode_t              tok_mode    = MODE_LINE;
  logic               cr_held     = 1'b0;
  logic [FIELD_W-1:0] learned_cnt = '0;
  logic [FIELD_W-1:0] field_cnt   = '0;
  logic [FIELD_W-1:0] exp_fields  = '0;
  logic [LINE_W-1:0]  line_cnt    = '0;
  logic               count_err   = 1'b0;

  csv_stream_tokenizer_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_data_byte        (in_data_byte),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_expected_fields (cfg_expected_fields),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_byte            (out_byte),
    .out_has_byte        (out_has_byte),
    .out_field_end       (out_field_end),
    .out_record_end      (out_record_end),
    .out_status          (out_status),
    .out_record_number   (out_record_number),
    .out_last            (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stall the result channel at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_REPORTS) begin
      $display("MISMATCH cycle %0d: %s", cycles, msg);
    end
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
    end
  endtask

  // Compare every accepted result against the oldest owed token.
  always @(posedge clk) begin : result_check
    token_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_tokens.size() == 0) begin
        report_mismatch($sformatf("unexpected result, byte %h", out_byte));
      end else begin
        want = owed_tokens.pop_front();
        check_field("out_byte", 16'(out_byte), 16'(want.tok_byte));
        check_field("has_byte", 16'(out_has_byte), 16'(want.has));
        check_field("field_end", 16'(out_field_end), 16'(want.fe));
        check_field("record_end", 16'(out_record_end), 16'(want.re));
        check_field("status", 16'(out_status), 16'(want.status));
        check_field("record_number", out_record_number, want.recno);
        check_field("last", 16'(out_last), 16'(want.last));
      end
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [1:0] err_status();
    return count_err ? ST_COUNT_ERR : ST_OK;
  endfunction

  function automatic logic [LINE_W-1:0] next_line(input logic [LINE_W-1:0] l);
    return (l == {LINE_W{1'b1}}) ? l : l + 1'b1;
  endfunction

  task automatic push_byte(input logic [7:0] c);
    step_tokens.push_back('{c, 1'b1, 1'b0, 1'b0, err_status(), line_cnt, 1'b0});
  endtask

  // Count a field; on a record end compare against the preset or learned count.
  task automatic close_field(input logic rec);
    logic [FIELD_W-1:0] target;
    if (field_cnt < FIELD_W'(MAX_FIELDS)) field_cnt = field_cnt + 1'b1;
    if (rec) begin
      target = (exp_fields != '0) ? exp_fields : learned_cnt;
      if (target == '0) learned_cnt = field_cnt;
      else if (target != field_cnt) count_err = 1'b1;
      field_cnt = '0;
    end
    step_tokens.push_back('{8'h00, 1'b0, 1'b1, rec, err_status(), line_cnt, 1'b0});
  endtask

  // Advance the parser by one character, CR folding already applied.
  task automatic parse_char(input logic [7:0] c);
    if (tok_mode == MODE_LINE) begin
      line_cnt = next_line(line_cnt);
      if (c == CH_HASH) tok_mode = MODE_COMMENT;
      else if (c != CH_LF) tok_mode = MODE_FSTART;
      if (tok_mode != MODE_FSTART) return;
    end
    case (tok_mode)
      MODE_FSTART: begin
        case (c)
          CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR: ;
          CH_COMMA: close_field(1'b0);
          CH_LF: begin
            close_field(1'b1);
            tok_mode = MODE_LINE;
          end
          CH_QUOTE: tok_mode = MODE_QUOTED;
          default: begin
            push_byte(c);
            tok_mode = MODE_PLAIN;
          end
        endcase
      end
      MODE_PLAIN: begin
        if (c == CH_COMMA || c == CH_LF) begin
          close_field(c == CH_LF);
          tok_mode = (c == CH_LF) ? MODE_LINE : MODE_FSTART;
        end else begin
          push_byte(c);
        end
      end
      MODE_QUOTED: begin
        if (c == CH_QUOTE) begin
          tok_mode = MODE_QSEEN;
        end else begin
          if (c == CH_LF) line_cnt = next_line(line_cnt);
          push_byte(c);
        end
      end
      MODE_QSEEN: begin
        if (c == CH_QUOTE) begin
          push_byte(c);
          tok_mode = MODE_QUOTED;
        end else if (c == CH_COMMA || c == CH_LF) begin
          close_field(c == CH_LF);
          tok_mode = (c == CH_LF) ? MODE_LINE : MODE_FSTART;
        end else begin
          // lazy quote: the stray quote and this byte are both data
          push_byte(CH_QUOTE);
          push_byte(c);
          tok_mode = MODE_QUOTED;
        end
      end
      MODE_COMMENT: begin
        if (c == CH_LF) tok_mode = MODE_LINE;
      end
      default: tok_mode = MODE_LINE;
    endcase
  endtask

  // Work out the tokens of one accepted item and append them to the owed list.
  task automatic predict_item(input logic kind, input logic [7:0] data);
    logic   taken;
    token_t t;
    step_tokens.delete();
    taken = 1'b0;
    if (kind == KIND_DATA) begin
      if (cr_held) begin
        cr_held = 1'b0;
        if (data == CH_LF) begin
          parse_char(CH_LF);
          taken = 1'b1;
        end else begin
          parse_char(CH_CR);
        end
      end
      if (!taken) begin
        if (data == CH_CR) cr_held = 1'b1;
        else parse_char(data);
      end
    end else begin
      cr_held = 1'b0;
      if (tok_mode == MODE_FSTART || tok_mode == MODE_PLAIN ||
          tok_mode == MODE_QUOTED || tok_mode == MODE_QSEEN) begin
        close_field(1'b1);
      end
      step_tokens.push_back('{8'h00, 1'b0, 1'b0, 1'b0, ST_EOI, line_cnt, 1'b0});
      tok_mode  = MODE_LINE;
      field_cnt = '0;
    end
    for (int i = 0; i < step_tokens.size(); i++) begin
      t      = step_tokens[i];
      t.last = (i == step_tokens.size() - 1);
      owed_tokens.push_back(t);
    end
  endtask

  // ------------------------------------------------------------------ drivers

  // Hold the item until accepted; idle first at the phase's rate.
  task automatic send_item(input logic kind, input logic [7:0] data);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_data_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    predict_item(kind, data);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(KIND_DATA, s[i]);
  endtask

  task automatic send_end();
    send_item(KIND_END, 8'($urandom));
  endtask

  // Drop valid and wait until every owed token has come, then let the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (owed_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_expected(input logic [FIELD_W-1:0] v);
    drain();
    cfg_valid           <= 1'b1;
    cfg_expected_fields <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    exp_fields = v;
  endtask

  function automatic logic [7:0] byte_except(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] v;
    do v = 8'($urandom); while (v == a || v == b);
    return v;
  endfunction

  function automatic logic [7:0] letter();
    return 8'($urandom_range(8'h7A, 8'h30));
  endfunction

  // One field: empty, plain, plain after whitespace, or quoted with escapes.
  task automatic send_field(input bit lone);
    int unsigned shape;
    shape = $urandom_range(5);
    // an empty lone field would read as a blank line
    if (shape == 0 && lone) shape = 2;
    case (shape)
      0: ;
      1, 2, 3: begin
        if (shape == 1) begin
          repeat ($urandom_range(2, 1))
            send_item(KIND_DATA, ($urandom_range(1) != 0) ? CH_SP : CH_TAB);
        end
        send_item(KIND_DATA, letter());
        repeat ($urandom_range(3)) send_item(KIND_DATA, byte_except(CH_COMMA, CH_LF));
      end
      default: begin
        send_item(KIND_DATA, CH_QUOTE);
        repeat ($urandom_range(4)) begin
          case ($urandom_range(5))
            0: begin
              send_item(KIND_DATA, CH_QUOTE);
              send_item(KIND_DATA, CH_QUOTE);
            end
            1: begin
              send_item(KIND_DATA, CH_QUOTE);
              send_item(KIND_DATA, letter());
            end
            default: send_item(KIND_DATA, byte_except(CH_QUOTE, CH_QUOTE));
          endcase
        end
        send_item(KIND_DATA, CH_QUOTE);
      end
    endcase
  endtask

  task automatic send_record(input int nf);
    for (int f = 0; f < nf; f++) begin
      send_field(nf == 1);
      if (f != nf - 1) send_item(KIND_DATA, CH_COMMA);
    end
    if ($urandom_range(3) == 0) send_item(KIND_DATA, CH_CR);
    send_item(KIND_DATA, CH_LF);
  endtask

  // -------------------------------------------------------------------- tests

  // First record sets the learned count, CR LF folds into LF.
  task automatic test_learning();
    idle_pct  = 0;
    stall_pct = 0;
    send_text("ab,c,\"d\"\n");
    send_text("x,,y\015\n");
  endtask

  // Blank line, comment line, and leading whitespace including a lone CR.
  task automatic test_skipped_lines();
    idle_pct  = 59;
    stall_pct = 0;
    send_text("\n# note, \"x\"\n \t\013\014\015z,1,2\n");
  endtask

  // Quoted comma and newline, doubled quote, lazy quote, bare quote, CR in quotes.
  task automatic test_quoting();
    idle_pct  = 0;
    stall_pct = 59;
    send_text("\"a,b\015\n\"\"c\",\"q\"x\",a\"b\n");
    send_text("\"r\015s\",2,\"z\"\n");
  endtask

  // End of input from every parser state, a dropped trailing CR included.
  task automatic test_end_of_input();
    idle_pct  = 30;
    stall_pct = 30;
    send_text("p,q,r");
    send_end();
    send_text("1,2,\"open");
    send_end();
    send_text("1,2,");
    send_end();
    send_text("1,2, ");
    send_end();
    send_text("1,2,\"x\"");
    send_end();
    send_text("1,2,3\015");
    send_end();
    send_text("#x");
    send_end();
    send_end();
  endtask

  // Preset count of one: a whitespace-only line counts as one field.
  task automatic test_preset_counts();
    write_expected(8'd1);
    idle_pct  = 0;
    stall_pct = 30;
    send_text("solo\n  \n\"\"\n");
    write_expected(8'd0);
  endtask

  // Well-formed records with random content; comments, blank lines, end marks between.
  task automatic test_random_records(input logic [FIELD_W-1:0] setting, input int unsigned idle,
                                     input int unsigned stall, input bit pause_midway);
    int start;
    int nf;
    bit paused;
    write_expected(setting);
    idle_pct  = idle;
    stall_pct = stall;
    start     = sent_items;
    paused    = 1'b0;
    while (sent_items - start < 20) begin
      nf = (exp_fields != '0) ? exp_fields : ((learned_cnt != '0) ? learned_cnt : 3);
      case ($urandom_range(11))
        0: begin
          send_item(KIND_DATA, CH_HASH);
          repeat ($urandom_range(3)) send_item(KIND_DATA, byte_except(CH_LF, CH_LF));
          send_item(KIND_DATA, CH_LF);
        end
        1: begin
          if ($urandom_range(1) != 0) send_item(KIND_DATA, CH_CR);
          send_item(KIND_DATA, CH_LF);
        end
        2: send_end();
        default: send_record(nf);
      endcase
      // hold off the sender until the block has delivered everything
      if (pause_midway && !paused && sent_items - start >= 10) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  // A record with the wrong count sets the sticky error; end mark still reports its own code.
  task automatic test_count_error();
    write_expected(8'd2);
    idle_pct  = 30;
    stall_pct = 30;
    send_text("   \n");
    send_text("a,b\n");
    send_end();
  endtask

  // Random bytes weighted toward the separators, with stray end marks.
  task automatic test_noise();
    logic [7:0] specials[6];
    specials  = '{CH_HASH, CH_QUOTE, CH_COMMA, CH_LF, CH_CR, CH_SP};
    idle_pct  = 59;
    stall_pct = 59;
    repeat (60) begin
      case ($urandom_range(9))
        0, 1, 2, 3: send_item(KIND_DATA, specials[$urandom_range(5)]);
        9: send_end();
        default: send_item(KIND_DATA, 8'($urandom));
      endcase
    end
    send_end();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_learning();
    test_skipped_lines();
    test_quoting();
    test_end_of_input();
    test_preset_counts();
    test_random_records(8'd0, 0, 0, 1'b0);
    test_random_records(8'($urandom_range(4, 1)), 59, 0, 1'b1);
    test_random_records(8'($urandom_range(6, 2)), 0, 59, 1'b0);
    test_random_records(8'($urandom_range(5, 1)), 30, 30, 1'b0);
    test_count_error();
    test_noise();

    drain();
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
